[src/ulr_pkg.sv]
package ulr_pkg;

  // byte codes with a meaning of their own
  localparam logic [7:0] Replacement = 8'h3F;
  localparam logic [7:0] Newline     = 8'h0A;

  // most words one input byte can cause
  localparam int MaxResults = 4;

  // leading-ones class of a byte, five stands for more than four
  localparam logic [2:0] OnesBad = 3'd5;

  // line and pending-character state
  typedef struct packed {
    logic [2:0][7:0] pend;
    logic [2:0]      exp_len;
    logic [1:0]      pend_cnt;
    logic [8:0]      line_bytes;
    logic [8:0]      line_chars;
    logic            skipping;
  } ulr_state_t;

  // up to four result words made from one input byte
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0]      kind;
    logic [3:0][7:0] data;
    logic [8:0]      byte_count;
    logic [8:0]      char_count;
    logic            ended_by_eof;
  } ulr_bundle_t;

  function automatic logic [2:0] lead_ones(input logic [7:0] b);
    logic [2:0] n;
    if (!b[7]) begin
      n = 3'd0;
    end else if (!b[6]) begin
      n = 3'd1;
    end else if (!b[5]) begin
      n = 3'd2;
    end else if (!b[4]) begin
      n = 3'd3;
    end else if (!b[3]) begin
      n = 3'd4;
    end else begin
      n = OnesBad;
    end
    return n;
  endfunction

endpackage

[src/ulr_ifs.sv]
// raw byte stream
interface ulr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// result words: text bytes and line summaries
interface ulr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic [8:0] byte_count;
  logic [8:0] char_count;
  logic       ended_by_eof;
  logic       last;
  modport source (output valid, output kind, output out_byte, output byte_count,
                  output char_count, output ended_by_eof, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input byte_count,
                  input char_count, input ended_by_eof, input last, output ready);
endinterface

// line capacity register write
interface ulr_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] line_capacity;
  modport source (output valid, output line_capacity, input ready);
  modport sink   (input valid, input line_capacity, output ready);
endinterface

[src/ulr_decode.sv]
module ulr_decode
  import ulr_pkg::*;
(
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  input  logic [8:0]  cap,
  input  ulr_state_t  st,
  output ulr_state_t  st_nxt,
  output ulr_bundle_t bun
);

  always_comb begin
    logic [2:0] ones;
    logic [8:0] room;
    logic [2:0] n;
    logic       skip_now;
    logic       end_line;
    logic       repl;

    ones     = lead_ones(in_byte);
    room     = cap - st.line_bytes;
    n        = 3'd0;
    end_line = 1'b0;
    repl     = 1'b0;
    skip_now = 1'b0;
    st_nxt   = st;
    bun      = '0;

    if (end_of_input) begin
      // pending character is broken by end of stream
      repl     = (st.exp_len != 3'd0);
      end_line = 1'b1;
    end else begin
      // a full line starts skipping before anything else
      skip_now = st.skipping || (st.exp_len == 3'd0 && st.line_bytes >= cap);
      st_nxt.skipping = skip_now;
      if (skip_now) begin
        end_line = (in_byte == Newline);
      end else if (st.exp_len != 3'd0) begin
        if (ones == 3'd1) begin
          if ({1'b0, st.pend_cnt} + 3'd1 >= st.exp_len) begin
            // character complete: held bytes then this one
            for (int j = 0; j < 3; j++) begin
              if (j < int'(st.pend_cnt)) begin
                bun.data[j] = st.pend[j];
              end
            end
            bun.data[st.pend_cnt] = in_byte;
            n = {1'b0, st.pend_cnt} + 3'd1;
            st_nxt.line_bytes = st.line_bytes + {6'd0, n};
            st_nxt.line_chars = st.line_chars + 9'd1;
            st_nxt.exp_len    = 3'd0;
            st_nxt.pend_cnt   = 2'd0;
          end else if (st.pend_cnt != 2'd3) begin
            st_nxt.pend[st.pend_cnt] = in_byte;
            st_nxt.pend_cnt          = st.pend_cnt + 2'd1;
          end
        end else begin
          repl = 1'b1;
        end
      end else begin
        // lead byte
        if (ones == 3'd0) begin
          if (in_byte == Newline) begin
            end_line = 1'b1;
          end else begin
            bun.data[0]       = in_byte;
            n                 = 3'd1;
            st_nxt.line_bytes = st.line_bytes + 9'd1;
            st_nxt.line_chars = st.line_chars + 9'd1;
          end
        end else if (ones == 3'd1 || ones == OnesBad) begin
          repl = 1'b1;
        end else if ({6'd0, ones} > room) begin
          st_nxt.skipping = 1'b1;
        end else begin
          st_nxt.pend[0]  = in_byte;
          st_nxt.pend_cnt = 2'd1;
          st_nxt.exp_len  = ones;
        end
      end
    end

    // replacement byte, always the first word
    if (repl) begin
      bun.data[0]       = Replacement;
      n                 = 3'd1;
      st_nxt.line_bytes = st.line_bytes + 9'd1;
      st_nxt.line_chars = st.line_chars + 9'd1;
      st_nxt.exp_len    = 3'd0;
      st_nxt.pend_cnt   = 2'd0;
    end

    // line summary closes the line and clears the state
    if (end_line) begin
      bun.kind[n[1:0]]  = 1'b1;
      bun.byte_count    = st_nxt.line_bytes;
      bun.char_count    = st_nxt.line_chars;
      bun.ended_by_eof  = end_of_input;
      n                 = n + 3'd1;
      st_nxt.line_bytes = 9'd0;
      st_nxt.line_chars = 9'd0;
      st_nxt.skipping   = 1'b0;
      st_nxt.exp_len    = 3'd0;
      st_nxt.pend_cnt   = 2'd0;
    end

    bun.cnt = n;
  end

endmodule

[src/utf8_line_reader.sv]
// UTF-8 line reader
//
// in_ch takes one word per cycle while ready: a byte, or an end-of-input mark.
// out_ch gives text bytes (kind 0) and one line summary (kind 1) at the end of
// every line with its byte and character counts; last marks the final word
// caused by one input word. Malformed data comes out as '?'.
// cfg_ch writes the line capacity; write it only while the block is idle.
//
// An input word sits in the input register, is decoded in one pass and
// loaded with its zero to four result words into the result register.
// The first result word is valid on out_ch as soon as the result register
// holds it. The rate is one input word per cycle while each word yields at
// most one result and the receiver is ready; a word that yields more than
// one result holds the result register until the output channel, which drains
// one word per cycle while the receiver is ready, has taken them all.
// A stalled receiver holds the result register; one more input word is
// still taken into the input register, then in_ch.ready drops.
// rst_n (synchronous) empties both registers, clears the line state and
// sets the capacity to 256.
module utf8_line_reader
  import ulr_pkg::*;
#(
  parameter int LINE_MAX = 256
) (
  input logic       clk,
  input logic       rst_n,
  ulr_in_if.sink    in_ch,
  ulr_out_if.source out_ch,
  ulr_cfg_if.sink   cfg_ch
);

  localparam int         CapMax = (LINE_MAX < 511) ? LINE_MAX : 511;
  localparam logic [8:0] CapLim = 9'(CapMax);

  logic [8:0]  cap_r;
  logic [8:0]  cap;
  logic        in_full_r;
  logic [7:0]  in_byte_r;
  logic        eof_r;
  ulr_state_t  st_r;
  ulr_state_t  st_nxt;
  ulr_bundle_t bun_nxt;
  ulr_bundle_t bun_r;
  logic [1:0]  idx_r;
  logic        in_fire;
  logic        out_fire;
  logic        out_last;
  logic        load;

  // capacity register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 9'd256;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.line_capacity;
    end
  end

  assign cap = (cap_r > CapLim) ? CapLim : cap_r;

  // handshakes
  assign out_last     = ({1'b0, idx_r} == bun_r.cnt - 3'd1);
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign load         = in_full_r && (bun_r.cnt == 3'd0 || (out_fire && out_last));
  assign in_ch.ready  = !in_full_r || load;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_fire || (in_full_r && !load);
    end
    if (in_fire) begin
      in_byte_r <= in_ch.in_byte;
      eof_r     <= in_ch.end_of_input;
    end
  end

  ulr_decode u_decode (
    .in_byte      (in_byte_r),
    .end_of_input (eof_r),
    .cap          (cap),
    .st           (st_r),
    .st_nxt       (st_nxt),
    .bun          (bun_nxt)
  );

  // line state, updated as a word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.exp_len    <= 3'd0;
      st_r.pend_cnt   <= 2'd0;
      st_r.line_bytes <= 9'd0;
      st_r.line_chars <= 9'd0;
      st_r.skipping   <= 1'b0;
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  // result register and word index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bun_r.cnt <= 3'd0;
      idx_r     <= 2'd0;
    end else if (load) begin
      bun_r <= bun_nxt;
      idx_r <= 2'd0;
    end else if (out_fire) begin
      if (out_last) begin
        bun_r.cnt <= 3'd0;
        idx_r     <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // output word
  assign out_ch.valid        = (bun_r.cnt != 3'd0);
  assign out_ch.kind         = bun_r.kind[idx_r];
  assign out_ch.out_byte     = bun_r.kind[idx_r] ? 8'd0 : bun_r.data[idx_r];
  assign out_ch.byte_count   = bun_r.kind[idx_r] ? bun_r.byte_count : 9'd0;
  assign out_ch.char_count   = bun_r.kind[idx_r] ? bun_r.char_count : 9'd0;
  assign out_ch.ended_by_eof = bun_r.kind[idx_r] ? bun_r.ended_by_eof : 1'b0;
  assign out_ch.last         = out_last;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bun_r.cnt <= 3'(MaxResults))
    else $error("result count out of range");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind) |-> out_ch.last)
    else $error("line summary not the final word");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last) |=> out_ch.valid)
    else $error("result words lost");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full_r && !load) |=> in_full_r)
    else $error("input word lost");

endmodule

[test/tb.sv]
module tb
  import ulr_pkg::*;
();

  localparam int unsigned CycleLimit = 300000;
  localparam int DrainCycles = 8;
  localparam logic KindText = 1'b0;
  localparam logic KindLine = 1'b1;

  // one output word as seen on the result channel
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [8:0] bc;
    logic [8:0] cc;
    logic       eof;
    logic       last;
  } word_t;

  // one stream word for the input channel
  typedef struct packed {
    logic       eoi;
    logic [7:0] b;
  } stim_t;

  // directed row: typed rows carry their single expected word
  typedef struct packed {
    logic       eoi;
    logic [7:0] b;
    logic       typed;
    word_t      want;
  } row_t;

  localparam word_t NoWord = '0;

  logic clk;
  logic rst_n;

  ulr_in_if  in_ch ();
  ulr_out_if out_ch ();
  ulr_cfg_if cfg_ch ();

  utf8_line_reader #(.LINE_MAX(256)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // line reader copy kept by the bench
  logic [7:0] held [3];
  logic [2:0] want_len;
  logic [1:0] held_cnt;
  logic [8:0] run_bytes;
  logic [8:0] run_chars;
  logic       skip_on;
  logic [8:0] cap_reg;

  word_t awaited_words[$];
  word_t step_words[$];
  stim_t batch[$];
  row_t  plan [25];

  int burst_left;
  int errors;
  int unsigned ticks;

  function automatic word_t text_word(input logic [7:0] b);
    word_t w;
    w = NoWord;
    w.kind = KindText;
    w.data = b;
    return w;
  endfunction

  function automatic word_t line_word(input logic [8:0] bc, input logic [8:0] cc,
                                      input logic eof);
    word_t w;
    w = NoWord;
    w.kind = KindLine;
    w.bc = bc;
    w.cc = cc;
    w.eof = eof;
    return w;
  endfunction

  function automatic int ones_of(input logic [7:0] b);
    int n;
    n = 0;
    while (n < 8 && b[7 - n]) n++;
    return n;
  endfunction

  function automatic void close_line(input logic eof);
    step_words.push_back(line_word(run_bytes, run_chars, eof));
    run_bytes = '0;
    run_chars = '0;
    skip_on = 1'b0;
    want_len = '0;
    held_cnt = '0;
  endfunction

  function automatic void put_replacement();
    step_words.push_back(text_word(Replacement));
    run_bytes = run_bytes + 9'd1;
    run_chars = run_chars + 9'd1;
    want_len = '0;
    held_cnt = '0;
  endfunction

  // words caused by one stream word, left in step_words
  function automatic void decode_byte(input logic eoi, input logic [7:0] b);
    int cap;
    int ones;
    step_words.delete();
    cap = (cap_reg > 9'd256) ? 256 : int'(cap_reg);
    ones = ones_of(b);
    if (eoi) begin
      if (want_len != 0) put_replacement();
      close_line(1'b1);
    end else begin
      // full line turns into skipping before the byte is looked at
      if (!skip_on && want_len == 0 && int'(run_bytes) >= cap) skip_on = 1'b1;
      if (skip_on) begin
        if (b == Newline) close_line(1'b0);
      end else if (want_len != 0) begin
        if (ones == 1) begin
          if (int'(held_cnt) + 1 >= int'(want_len)) begin
            for (int i = 0; i < int'(held_cnt); i++) step_words.push_back(text_word(held[i]));
            step_words.push_back(text_word(b));
            run_bytes = run_bytes + 9'(step_words.size());
            run_chars = run_chars + 9'd1;
            want_len = '0;
            held_cnt = '0;
          end else if (held_cnt < 2'd3) begin
            held[held_cnt] = b;
            held_cnt = held_cnt + 2'd1;
          end
        end else begin
          put_replacement();
        end
      end else if (ones == 0) begin
        if (b == Newline) begin
          close_line(1'b0);
        end else begin
          step_words.push_back(text_word(b));
          run_bytes = run_bytes + 9'd1;
          run_chars = run_chars + 9'd1;
        end
      end else if (ones == 1 || ones > 4) begin
        put_replacement();
      end else if (ones > cap - int'(run_bytes)) begin
        skip_on = 1'b1;
      end else begin
        held[0] = b;
        held_cnt = 2'd1;
        want_len = 3'(ones);
      end
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] b;
    b = 8'($urandom);
    case (len)
      2: b = {3'b110, b[4:0]};
      3: b = {4'b1110, b[3:0]};
      default: b = {5'b11110, b[2:0]};
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // mostly well-formed characters, with broken sequences and noise mixed in
  function automatic void queue_random_chars(input int n);
    int r;
    int len;
    int keep;
    logic [7:0] b;
    while (batch.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        batch.push_back('{1'b0, 8'($urandom_range(0, 127))});
      end else if (r < 50) begin
        batch.push_back('{1'b0, Newline});
      end else if (r < 80) begin
        len = (r < 62) ? 2 : ((r < 72) ? 3 : 4);
        batch.push_back('{1'b0, lead_byte(len)});
        repeat (len - 1) batch.push_back('{1'b0, cont_byte()});
      end else if (r < 87) begin
        len = $urandom_range(2, 4);
        keep = $urandom_range(0, len - 2);
        batch.push_back('{1'b0, lead_byte(len)});
        repeat (keep) batch.push_back('{1'b0, cont_byte()});
        // anything but a continuation breaks it
        b = 8'($urandom_range(0, 191));
        if (b >= 8'd128) b = b + 8'd64;
        batch.push_back('{1'b0, b});
      end else if (r < 95) begin
        batch.push_back('{1'b0, 8'($urandom)});
      end else if (r < 98) begin
        batch.push_back('{1'b1, 8'($urandom)});
      end else begin
        batch.push_back('{1'b0, 8'($urandom_range(248, 255))});
      end
    end
  endfunction

  // one stream word, sent in bursts with random gaps
  task automatic send_word(input logic eoi, input logic [7:0] b, input logic typed,
                           input word_t want);
    word_t w;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    decode_byte(eoi, b);
    if (typed) begin
      w = want;
      w.last = 1'b1;
      awaited_words.push_back(w);
    end else begin
      foreach (step_words[i]) awaited_words.push_back(step_words[i]);
    end
  endtask

  // sender holds off until every expected word has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic play_batch();
    while (batch.size() != 0) begin
      if ($urandom_range(0, 29) == 0) wait_idle();
      send_word(batch[0].eoi, batch[0].b, 1'b0, NoWord);
      void'(batch.pop_front());
    end
  endtask

  task automatic write_capacity(input logic [8:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.line_capacity <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_reg = v;
  endtask

  function automatic void note_error(input word_t want, input word_t got, input logic none);
    errors++;
    if (errors <= 10) begin
      if (none) begin
        $display("tb: unexpected word kind=%0d byte=%02h bc=%0d cc=%0d eof=%0d last=%0d",
                 got.kind, got.data, got.bc, got.cc, got.eof, got.last);
      end else begin
        $display("tb: mismatch exp kind=%0d byte=%02h bc=%0d cc=%0d eof=%0d last=%0d",
                 want.kind, want.data, want.bc, want.cc, want.eof, want.last);
        $display("tb:          got kind=%0d byte=%02h bc=%0d cc=%0d eof=%0d last=%0d",
                 got.kind, got.data, got.bc, got.cc, got.eof, got.last);
      end
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial ticks = 0;
  always @(posedge clk) begin
    ticks <= ticks + 1;
    if (ticks > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side: check each word, stall on a changing pattern
  initial begin
    word_t got;
    word_t want;
    int stall_mode;
    int stall_left;
    int beat;
    stall_mode = 0;
    stall_left = 0;
    beat = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.out_byte, out_ch.byte_count, out_ch.char_count,
                out_ch.ended_by_eof, out_ch.last};
        if (awaited_words.size() == 0) begin
          note_error(NoWord, got, 1'b1);
        end else begin
          want = awaited_words.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.bc !== want.bc ||
              got.cc !== want.cc || got.eof !== want.eof || got.last !== want.last)
            note_error(want, got, 1'b0);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      beat++;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (beat % 5 != 0);
      endcase
    end
  end

  // stimulus
  initial begin
    logic [8:0] caps [9];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.end_of_input <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.line_capacity <= 9'd256;
    errors = 0;
    burst_left = 0;
    cap_reg = 9'd256;
    want_len = '0;
    held_cnt = '0;
    run_bytes = '0;
    run_chars = '0;
    skip_on = 1'b0;

    // directed rows at reset capacity
    plan = '{
      '{1'b1, 8'h00, 1'b1, line_word(9'd0, 9'd0, 1'b1)},   // end of input on empty line
      '{1'b0, 8'h00, 1'b1, text_word(8'h00)},
      '{1'b0, 8'h7F, 1'b1, text_word(8'h7F)},
      '{1'b0, 8'h80, 1'b1, text_word(Replacement)},          // stray continuation
      '{1'b0, 8'hFF, 1'b1, text_word(Replacement)},          // eight leading ones
      '{1'b0, 8'hF8, 1'b1, text_word(Replacement)},          // five leading ones
      '{1'b0, 8'hC3, 1'b0, NoWord},
      '{1'b0, 8'hA9, 1'b0, NoWord},
      '{1'b0, 8'hE2, 1'b0, NoWord},
      '{1'b0, 8'h82, 1'b0, NoWord},
      '{1'b0, 8'hAC, 1'b0, NoWord},
      '{1'b0, 8'hF0, 1'b0, NoWord},
      '{1'b0, 8'h9F, 1'b0, NoWord},
      '{1'b0, 8'h98, 1'b0, NoWord},
      '{1'b0, 8'h80, 1'b0, NoWord},
      '{1'b0, 8'hC3, 1'b0, NoWord},
      '{1'b0, 8'h41, 1'b1, text_word(Replacement)},          // broken by ascii, dropped
      '{1'b0, 8'hE2, 1'b0, NoWord},
      '{1'b0, Newline, 1'b1, text_word(Replacement)},        // broken by newline, dropped
      '{1'b0, Newline, 1'b0, NoWord},
      '{1'b0, 8'hF0, 1'b0, NoWord},
      '{1'b1, 8'hFF, 1'b0, NoWord},                          // end of input mid character
      '{1'b0, Newline, 1'b1, line_word(9'd0, 9'd0, 1'b0)},
      '{1'b0, 8'hC0, 1'b0, NoWord},
      '{1'b0, 8'hBF, 1'b0, NoWord}
    };
    caps = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd12, 9'd255, 9'd256,
             9'($urandom_range(1, 256))};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_word(plan[i].eoi, plan[i].b, plan[i].typed, plan[i].want);

    // capacity lowered under a pending character
    wait_idle();
    send_word(1'b0, 8'hE2, 1'b0, NoWord);
    wait_idle();
    write_capacity(9'd1);
    send_word(1'b0, 8'h82, 1'b0, NoWord);
    send_word(1'b0, 8'hAC, 1'b0, NoWord);
    send_word(1'b0, Newline, 1'b0, NoWord);

    // random phases over a spread of capacities
    foreach (caps[p]) begin
      wait_idle();
      write_capacity(caps[p]);
      if (caps[p] == 9'd12) begin
        // one line past full capacity
        repeat (14) batch.push_back('{1'b0, 8'($urandom_range(32, 126))});
        batch.push_back('{1'b0, Newline});
      end
      queue_random_chars(batch.size() + 19);
      play_batch();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
